### rtl/core/modinv_pkg.sv
// modinv_pkg: shared types and constants for the modular inverse unit
// request and result structs, datapath operation codes, controller states
// no dependencies
package modinv_pkg;

  localparam int WORD_BITS  = 64;
  localparam int MOD_BITS   = WORD_BITS - 1;
  localparam int SHIFT_BITS = $clog2(WORD_BITS);

  typedef struct packed {
    logic signed [WORD_BITS-1:0] value;
    logic        [MOD_BITS-1:0]  modulus;
  } req_t;

  typedef struct packed {
    logic [MOD_BITS-1:0] inverse;
    logic                has_inverse;
  } res_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_REDUCE,
    OP_RED_FIX,
    OP_STEP_INIT,
    OP_ALIGN,
    OP_SUB,
    OP_FIN_ABS
  } dp_op_t;

  typedef struct packed {
    logic red_last;
    logic nr_zero;
    logic can_align;
    logic k_zero;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_RED_FIX,
    ST_CHECK,
    ST_ALIGN,
    ST_SUB,
    ST_FIN_ABS,
    ST_FIN_OUT
  } state_t;

endpackage

### rtl/core/modinv_datapath.sv
// modinv_datapath: operand registers, remainder/coefficient pairs, shift-subtract unit
// executes one operation per cycle as commanded by modinv_ctrl
// depends on modinv_pkg
module modinv_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  modinv_pkg::dp_op_t    op,
  input  logic                  fin_out,
  input  modinv_pkg::req_t      request,
  output modinv_pkg::dp_status_t status,
  output logic                  done,
  output modinv_pkg::res_t      result
);

  localparam int W = modinv_pkg::WORD_BITS;
  localparam int M = modinv_pkg::MOD_BITS;
  localparam int S = modinv_pkg::SHIFT_BITS;

  logic [W-1:0] dividend;
  logic         neg_in;
  logic [M-1:0] m;
  logic [M-1:0] r;
  logic [M-1:0] nr;
  logic [W-1:0] t;
  logic [W-1:0] nt;
  logic [W-1:0] d;
  logic [S-1:0] k;
  logic [S-1:0] cnt;
  logic         t_neg;

  logic [W-1:0] val_u;
  logic [W-1:0] m_w;
  logic [W-1:0] rem_sh;
  logic [W-1:0] rem_sub;
  logic         rem_ge;
  logic [M-1:0] fix_nr;
  logic         d_le;
  logic [M-1:0] r_sel;
  logic [W-1:0] dt;
  logic [W-1:0] t_sel;
  logic [W-1:0] t_abs;
  logic [W-1:0] fin_a_w;
  logic [M-1:0] fin_a;
  logic [M-1:0] fin_inv;
  logic         has;

  always_comb begin
    val_u   = request.value;
    m_w     = {1'b0, m};
    // restoring remainder step, one dividend bit per cycle
    rem_sh  = {nr, dividend[W-1]};
    rem_ge  = rem_sh >= m_w;
    rem_sub = rem_sh - m_w;
    fix_nr  = (neg_in && (nr != '0)) ? (m - nr) : nr;
    // one quotient bit: subtract aligned divisor from r and aligned nt from t
    d_le    = d <= {1'b0, r};
    r_sel   = d_le ? (r - d[M-1:0]) : r;
    dt      = nt << k;
    t_sel   = d_le ? (t - dt) : t;
    t_abs   = t[W-1] ? (~t + W'(1)) : t;
    fin_a_w = (t >= m_w) ? (t - m_w) : t;
    fin_a   = fin_a_w[M-1:0];
    fin_inv = t_neg ? ((fin_a != '0) ? (m - fin_a) : '0) : fin_a;
    has     = (m != '0) && (r == M'(1));
  end

  always_comb begin
    status.red_last  = cnt == S'(W - 1);
    status.nr_zero   = nr == '0;
    status.can_align = {d[W-2:0], 1'b0} <= {1'b0, r};
    status.k_zero    = k == '0;
  end

  always_ff @(posedge clk) begin
    unique case (op)
      modinv_pkg::OP_IDLE: begin
      end
      modinv_pkg::OP_LOAD: begin
        dividend <= request.value[W-1] ? (~val_u + W'(1)) : val_u;
        neg_in   <= request.value[W-1];
        m        <= request.modulus;
        nr       <= '0;
        cnt      <= '0;
      end
      modinv_pkg::OP_REDUCE: begin
        nr       <= rem_ge ? rem_sub[M-1:0] : rem_sh[M-1:0];
        dividend <= {dividend[W-2:0], 1'b0};
        cnt      <= cnt + S'(1);
      end
      modinv_pkg::OP_RED_FIX: begin
        nr <= fix_nr;
        r  <= m;
        t  <= '0;
        nt <= W'(1);
      end
      modinv_pkg::OP_STEP_INIT: begin
        d <= {1'b0, nr};
        k <= '0;
      end
      modinv_pkg::OP_ALIGN: begin
        if (status.can_align) begin
          d <= {d[W-2:0], 1'b0};
          k <= k + S'(1);
        end
      end
      modinv_pkg::OP_SUB: begin
        if (k != '0) begin
          r <= r_sel;
          t <= t_sel;
          d <= {1'b0, d[W-1:1]};
          k <= k - S'(1);
        end else begin
          // quotient step complete: shift the pairs
          r  <= nr;
          nr <= r_sel;
          t  <= nt;
          nt <= t_sel;
        end
      end
      modinv_pkg::OP_FIN_ABS: begin
        t     <= t_abs;
        t_neg <= t[W-1];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fin_out) begin
      result.inverse     <= has ? fin_inv : '0;
      result.has_inverse <= has;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin_out;
    end
  end

endmodule

### rtl/core/modinv_ctrl.sv
// modinv_ctrl: sequencer for reduction, quotient steps and final correction
// drives datapath operations from datapath status
// depends on modinv_pkg
module modinv_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  modinv_pkg::dp_status_t status,
  output logic                   busy,
  output modinv_pkg::dp_op_t     op,
  output logic                   fin_out
);

  modinv_pkg::state_t state;
  modinv_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= modinv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      modinv_pkg::ST_IDLE: begin
        if (start) state_next = modinv_pkg::ST_REDUCE;
      end
      modinv_pkg::ST_REDUCE: begin
        if (status.red_last) state_next = modinv_pkg::ST_RED_FIX;
      end
      modinv_pkg::ST_RED_FIX: begin
        state_next = modinv_pkg::ST_CHECK;
      end
      modinv_pkg::ST_CHECK: begin
        state_next = status.nr_zero ? modinv_pkg::ST_FIN_ABS : modinv_pkg::ST_ALIGN;
      end
      modinv_pkg::ST_ALIGN: begin
        if (!status.can_align) state_next = modinv_pkg::ST_SUB;
      end
      modinv_pkg::ST_SUB: begin
        if (status.k_zero) state_next = modinv_pkg::ST_CHECK;
      end
      modinv_pkg::ST_FIN_ABS: begin
        state_next = modinv_pkg::ST_FIN_OUT;
      end
      modinv_pkg::ST_FIN_OUT: begin
        state_next = modinv_pkg::ST_IDLE;
      end
      default: begin
        state_next = modinv_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy    = state != modinv_pkg::ST_IDLE;
    op      = modinv_pkg::OP_IDLE;
    fin_out = 1'b0;
    unique case (state)
      modinv_pkg::ST_IDLE: begin
        if (start) op = modinv_pkg::OP_LOAD;
      end
      modinv_pkg::ST_REDUCE:  op = modinv_pkg::OP_REDUCE;
      modinv_pkg::ST_RED_FIX: op = modinv_pkg::OP_RED_FIX;
      modinv_pkg::ST_CHECK:   op = modinv_pkg::OP_STEP_INIT;
      modinv_pkg::ST_ALIGN:   op = modinv_pkg::OP_ALIGN;
      modinv_pkg::ST_SUB:     op = modinv_pkg::OP_SUB;
      modinv_pkg::ST_FIN_ABS: op = modinv_pkg::OP_FIN_ABS;
      modinv_pkg::ST_FIN_OUT: fin_out = 1'b1;
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/modular_inverse_ext_euclid_unit.sv
// modular_inverse_ext_euclid_unit: modular inverse by the extended Euclidean algorithm
// instantiates modinv_ctrl and modinv_datapath, types from modinv_pkg
//
// usage: drive request (signed value, modulus) and raise start while busy is low;
// the request is taken at that edge and busy rises the next cycle.
// result carries inverse in 0..modulus-1 and has_inverse; it is valid for the single
// cycle in which done is high and must be captured then, there is no holding it off.
// a modulus of zero gives inverse 0 with has_inverse 0, a modulus of one gives 0 with 1.
// sequence: bit-serial reduction of the value, a fixup step, then per quotient step
// an align pass and a shift-subtract pass over the quotient bits through one shared
// shift-subtract unit, then final correction; done rises the cycle after.
// the total time is data dependent.
// one request at a time: busy falls in the cycle done is high, so a new request
// can be taken at the edge that ends the done cycle.
// reset (rst, synchronous) returns the sequencer to idle and clears done.
module modular_inverse_ext_euclid_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  modinv_pkg::req_t request,
  output logic             done,
  output modinv_pkg::res_t result
);

  modinv_pkg::dp_op_t     op;
  modinv_pkg::dp_status_t status;
  logic                   fin_out;

  modinv_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .status  (status),
    .busy    (busy),
    .op      (op),
    .fin_out (fin_out)
  );

  modinv_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .fin_out (fin_out),
    .request (request),
    .status  (status),
    .done    (done),
    .result  (result)
  );

endmodule
